@@ hw/rtl/first_fit_allocator_with_wait_queue_assert.svh @@
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_ALLOCATOR_WITH_WAIT_QUEUE_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_WITH_WAIT_QUEUE_ASSERT_SVH

// Implication checked every clock while out of reset.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked every clock while out of reset.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ffa_pkg.sv @@
// Shared constants for the first-fit allocator.
package ffa_pkg;
	localparam int unsigned SizeW = 31;
	localparam int unsigned TickW = 32;
	localparam int unsigned SDataW = 64;
	localparam int unsigned MDataW = 160;
	localparam int unsigned KindW = 3;

	localparam logic [KindW-1:0] EV_GRANT = 3'd0;
	localparam logic [KindW-1:0] EV_QUEUED = 3'd1;
	localparam logic [KindW-1:0] EV_RELEASED = 3'd2;
	localparam logic [KindW-1:0] EV_STATUS = 3'd3;
	localparam logic [KindW-1:0] EV_OVERFLOW = 3'd4;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_REQUEST = 1'b1;
endpackage

@@ hw/rtl/ffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/first_fit_allocator_with_wait_queue.sv @@
// A request scans the free entries one at a time, moves entries when a block is used up,
// and gives one output beat per result. A tick checks each job, shifts the job entries
// and merges each release into the free list, then grants from the queue head until one
// fails; all work runs on one sequencer, one item at a time.
// Reset (and a memory_size write) empties all tables, then ST_INIT loads free entry 0.
module first_fit_allocator_with_wait_queue #(
	parameter int FREE_DEPTH = 32,
	parameter int JOB_DEPTH = 16,
	parameter int WAIT_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ffa_pkg::SizeW-1:0]          cfg_wdata,  // memory_size
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ffa_pkg::SDataW-1:0]         s_tdata,    // request_size, request_duration
	input  logic                               s_tuser,    // operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// block_address, block_length, end_tick, current_tick, queued_total, busy_flag
	output logic [ffa_pkg::MDataW-1:0]         m_tdata,
	output logic [ffa_pkg::KindW-1:0]          m_tuser,    // event_kind
	output logic                               m_tlast
);
	localparam int FAW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
	localparam int FCW = $clog2(FREE_DEPTH + 1);
	localparam int JAW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int JCW = $clog2(JOB_DEPTH + 1);
	localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WCW = $clog2(WAIT_DEPTH + 1);
	localparam int SW = ffa_pkg::SizeW;
	localparam int TW = ffa_pkg::TickW;

	typedef enum logic [22:0] {
		ST_INIT     = 23'h000001,
		ST_IDLE     = 23'h000002,
		ST_REL_RD   = 23'h000004,
		ST_REL_CHK  = 23'h000008,
		ST_JSH_RD   = 23'h000010,
		ST_JSH_WR   = 23'h000020,
		ST_GB_START = 23'h000040,
		ST_GB_RD    = 23'h000080,
		ST_GB_CHK   = 23'h000100,
		ST_GB_DEC   = 23'h000200,
		ST_GB_INS   = 23'h000400,
		ST_GB_OK    = 23'h000800,
		ST_FSH_RD   = 23'h001000,
		ST_FSH_WR   = 23'h002000,
		ST_WQ_RD    = 23'h004000,
		ST_WQ_GET   = 23'h008000,
		ST_GR_START = 23'h010000,
		ST_GR_RD    = 23'h020000,
		ST_GR_CHK   = 23'h040000,
		ST_GR_JOB   = 23'h080000,
		ST_GR_DONE  = 23'h100000,
		ST_STATUS   = 23'h200000,
		ST_EMIT     = 23'h400000
	} state_t;

	state_t state_q, ret_q, fret_q;

	logic [SW-1:0]  mem_size_q;
	logic [FCW-1:0] fc_q, pos_q, fj_q, fk_q;
	logic [JCW-1:0] jc_q, k_q, jj_q;
	logic [WCW-1:0] wc_q;
	logic [WAW-1:0] head_q, tail_q;
	logic [TW-1:0]  tick_q, waited_q, gend_q;
	logic           op_q, ok_q, fup_q, have_next_q;
	logic [SW-1:0]  gsize_q, gdur_q, gaddr_q, rel_s_q, rel_l_q;
	logic [SW-1:0]  prev_s_q, prev_l_q, next_s_q, next_l_q;

	logic [ffa_pkg::KindW-1:0] ev_kind_q;
	logic [SW-1:0]  ev_addr_q, ev_len_q;
	logic [TW-1:0]  ev_end_q;
	logic           ev_last_q;

	logic                  m_tvalid_q, m_tlast_q;
	logic [ffa_pkg::MDataW-1:0] m_tdata_q;
	logic [ffa_pkg::KindW-1:0]  m_tuser_q;

	// RAM ports
	logic             f_we, j_we, w_we;
	logic [FAW-1:0]   f_waddr, f_raddr;
	logic [2*SW-1:0]  f_wdata, f_rdata;
	logic [JAW-1:0]   j_waddr, j_raddr;
	logic [2*SW+TW-1:0] j_wdata, j_rdata;
	logic [WAW-1:0]   w_waddr, w_raddr;
	logic [2*SW-1:0]  w_wdata, w_rdata;

	logic [SW-1:0] f_rd_start, f_rd_len;
	logic [FCW-1:0] fj_inc, fj_dec, pos_dec;
	logic [JCW-1:0] jj_inc;
	logic [TW-1:0] gb_prev_end, gb_end, job_end_new;
	logic gb_left, gb_right, busy;
	logic emit_go;

	assign f_rd_start = f_rdata[SW-1:0];
	assign f_rd_len = f_rdata[2*SW-1:SW];
	assign fj_inc = fj_q + FCW'(1);
	assign fj_dec = fj_q - FCW'(1);
	assign pos_dec = pos_q - FCW'(1);
	assign jj_inc = jj_q + JCW'(1);
	assign gb_prev_end = {1'b0, prev_s_q} + {1'b0, prev_l_q};
	assign gb_end = {1'b0, rel_s_q} + {1'b0, rel_l_q};
	assign gb_left = (pos_q != '0) && (gb_prev_end == {1'b0, rel_s_q});
	assign gb_right = have_next_q && ({1'b0, next_s_q} == gb_end);
	assign job_end_new = tick_q + {1'b0, gdur_q};
	assign busy = (jc_q != '0) || (wc_q != '0);
	// output register loads a new beat this cycle
	assign emit_go = !cfg_we && (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	ffa_ram #(.WIDTH(2*SW), .DEPTH(FREE_DEPTH)) u_free_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);
	ffa_ram #(.WIDTH(2*SW+TW), .DEPTH(JOB_DEPTH)) u_job_ram (
		.clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
		.raddr(j_raddr), .rdata(j_rdata)
	);
	ffa_ram #(.WIDTH(2*SW), .DEPTH(WAIT_DEPTH)) u_wait_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	always_comb begin
		f_we = 1'b0;
		f_waddr = '0;
		f_wdata = '0;
		f_raddr = '0;
		j_we = 1'b0;
		j_waddr = '0;
		j_wdata = {job_end_new, gsize_q, gaddr_q};
		j_raddr = k_q[JAW-1:0];
		w_we = 1'b0;
		w_waddr = tail_q;
		w_wdata = {gdur_q, gsize_q};
		w_raddr = head_q;
		case (state_q)
			ST_INIT: begin
				f_we = 1'b1;
				f_wdata = {mem_size_q, {SW{1'b0}}};
			end
			ST_GB_RD: f_raddr = pos_q[FAW-1:0];
			ST_GR_RD: f_raddr = fk_q[FAW-1:0];
			ST_FSH_RD: f_raddr = fup_q ? fj_dec[FAW-1:0] : fj_inc[FAW-1:0];
			ST_FSH_WR: begin
				f_we = 1'b1;
				f_waddr = fj_q[FAW-1:0];
				f_wdata = f_rdata;
			end
			ST_GR_CHK: begin
				f_we = f_rd_len > gsize_q;
				f_waddr = fk_q[FAW-1:0];
				f_wdata = {f_rd_len - gsize_q, f_rd_start + gsize_q};
			end
			ST_GB_DEC: begin
				if (gb_left) begin
					f_we = 1'b1;
					f_waddr = pos_dec[FAW-1:0];
					f_wdata = gb_right ? {prev_l_q + rel_l_q + next_l_q, prev_s_q}
					                   : {prev_l_q + rel_l_q, prev_s_q};
				end else if (gb_right) begin
					f_we = 1'b1;
					f_waddr = pos_q[FAW-1:0];
					f_wdata = {next_l_q + rel_l_q, rel_s_q};
				end
			end
			ST_GB_INS: begin
				f_we = 1'b1;
				f_waddr = pos_q[FAW-1:0];
				f_wdata = {rel_l_q, rel_s_q};
			end
			ST_JSH_RD: j_raddr = jj_inc[JAW-1:0];
			ST_JSH_WR: begin
				j_we = 1'b1;
				j_waddr = jj_q[JAW-1:0];
				j_wdata = j_rdata;
			end
			ST_GR_JOB: begin
				j_we = 1'b1;
				j_waddr = jc_q[JAW-1:0];
			end
			ST_GR_DONE: w_we = (op_q == ffa_pkg::OP_REQUEST) && !ok_q
			                   && (wc_q < WCW'(WAIT_DEPTH));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ret_q <= ST_IDLE;
			fret_q <= ST_IDLE;
			mem_size_q <= SW'(1024);
			fc_q <= '0;
			pos_q <= '0;
			fj_q <= '0;
			fk_q <= '0;
			jc_q <= '0;
			k_q <= '0;
			jj_q <= '0;
			wc_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			tick_q <= '1;
			waited_q <= '0;
			gend_q <= '0;
			op_q <= 1'b0;
			ok_q <= 1'b0;
			fup_q <= 1'b0;
			have_next_q <= 1'b0;
			gsize_q <= '0;
			gdur_q <= '0;
			gaddr_q <= '0;
			rel_s_q <= '0;
			rel_l_q <= '0;
			prev_s_q <= '0;
			prev_l_q <= '0;
			next_s_q <= '0;
			next_l_q <= '0;
			ev_kind_q <= ffa_pkg::EV_STATUS;
			ev_addr_q <= '0;
			ev_len_q <= '0;
			ev_end_q <= '0;
			ev_last_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !emit_go) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				mem_size_q <= cfg_wdata;
				fc_q <= '0;
				jc_q <= '0;
				wc_q <= '0;
				head_q <= '0;
				tail_q <= '0;
				tick_q <= '1;
				waited_q <= '0;
				state_q <= ST_INIT;
			end else begin
				case (state_q)
					ST_INIT: begin
						fc_q <= (mem_size_q != '0) ? FCW'(1) : '0;
						state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (s_tvalid) begin
							op_q <= s_tuser;
							gsize_q <= s_tdata[SW-1:0];
							gdur_q <= s_tdata[2*SW-1:SW];
							if (s_tuser == ffa_pkg::OP_TICK) begin
								tick_q <= tick_q + TW'(1);
								k_q <= '0;
								state_q <= ST_REL_RD;
							end else begin
								state_q <= ST_GR_START;
							end
						end
					end
					ST_REL_RD: state_q <= (k_q >= jc_q) ? ST_WQ_RD : ST_REL_CHK;
					ST_REL_CHK: begin
						if (j_rdata[2*SW+TW-1:2*SW] == tick_q) begin
							rel_s_q <= j_rdata[SW-1:0];
							rel_l_q <= j_rdata[2*SW-1:SW];
							jj_q <= k_q;
							state_q <= ST_JSH_RD;
						end else begin
							k_q <= k_q + JCW'(1);
							state_q <= ST_REL_RD;
						end
					end
					ST_JSH_RD: begin
						if (jj_inc < jc_q) begin
							state_q <= ST_JSH_WR;
						end else begin
							jc_q <= jc_q - JCW'(1);
							state_q <= ST_GB_START;
						end
					end
					ST_JSH_WR: begin
						jj_q <= jj_inc;
						state_q <= ST_JSH_RD;
					end
					ST_GB_START: begin
						pos_q <= '0;
						state_q <= (rel_l_q == '0) ? ST_GB_OK : ST_GB_RD;
					end
					ST_GB_RD: begin
						if (pos_q >= fc_q) begin
							have_next_q <= 1'b0;
							state_q <= ST_GB_DEC;
						end else begin
							state_q <= ST_GB_CHK;
						end
					end
					ST_GB_CHK: begin
						if (f_rd_start <= rel_s_q) begin
							prev_s_q <= f_rd_start;
							prev_l_q <= f_rd_len;
							pos_q <= pos_q + FCW'(1);
							state_q <= ST_GB_RD;
						end else begin
							next_s_q <= f_rd_start;
							next_l_q <= f_rd_len;
							have_next_q <= 1'b1;
							state_q <= ST_GB_DEC;
						end
					end
					ST_GB_DEC: begin
						if (gb_left && gb_right) begin
							// merged both sides: drop the right neighbor
							fup_q <= 1'b0;
							fj_q <= pos_q;
							fret_q <= ST_GB_OK;
							state_q <= ST_FSH_RD;
						end else if (gb_left || gb_right) begin
							state_q <= ST_GB_OK;
						end else if (fc_q >= FCW'(FREE_DEPTH)) begin
							ev_kind_q <= ffa_pkg::EV_OVERFLOW;
							ev_addr_q <= rel_s_q;
							ev_len_q <= rel_l_q;
							ev_end_q <= '0;
							ev_last_q <= 1'b0;
							ret_q <= ST_REL_RD;
							state_q <= ST_EMIT;
						end else begin
							fup_q <= 1'b1;
							fj_q <= fc_q;
							fret_q <= ST_GB_INS;
							state_q <= ST_FSH_RD;
						end
					end
					ST_GB_INS: state_q <= ST_GB_OK;
					ST_GB_OK: begin
						ev_kind_q <= ffa_pkg::EV_RELEASED;
						ev_addr_q <= rel_s_q;
						ev_len_q <= rel_l_q;
						ev_end_q <= '0;
						ev_last_q <= 1'b0;
						ret_q <= ST_REL_RD;
						state_q <= ST_EMIT;
					end
					ST_FSH_RD: begin
						if (fup_q) begin
							if (fj_q > pos_q) begin
								state_q <= ST_FSH_WR;
							end else begin
								fc_q <= fc_q + FCW'(1);
								state_q <= fret_q;
							end
						end else begin
							if (fj_inc < fc_q) begin
								state_q <= ST_FSH_WR;
							end else begin
								fc_q <= fc_q - FCW'(1);
								state_q <= fret_q;
							end
						end
					end
					ST_FSH_WR: begin
						fj_q <= fup_q ? fj_dec : fj_inc;
						state_q <= ST_FSH_RD;
					end
					ST_WQ_RD: state_q <= (wc_q == '0) ? ST_STATUS : ST_WQ_GET;
					ST_WQ_GET: begin
						gsize_q <= w_rdata[SW-1:0];
						gdur_q <= w_rdata[2*SW-1:SW];
						state_q <= ST_GR_START;
					end
					ST_GR_START: begin
						fk_q <= '0;
						if (jc_q >= JCW'(JOB_DEPTH)) begin
							ok_q <= 1'b0;
							state_q <= ST_GR_DONE;
						end else begin
							state_q <= ST_GR_RD;
						end
					end
					ST_GR_RD: begin
						if (fk_q >= fc_q) begin
							ok_q <= 1'b0;
							state_q <= ST_GR_DONE;
						end else begin
							state_q <= ST_GR_CHK;
						end
					end
					ST_GR_CHK: begin
						if (f_rd_len >= gsize_q) begin
							gaddr_q <= f_rd_start;
							if (f_rd_len > gsize_q) begin
								state_q <= ST_GR_JOB;
							end else begin
								// exact fit: block leaves the list
								fup_q <= 1'b0;
								fj_q <= fk_q;
								pos_q <= fk_q;
								fret_q <= ST_GR_JOB;
								state_q <= ST_FSH_RD;
							end
						end else begin
							fk_q <= fk_q + FCW'(1);
							state_q <= ST_GR_RD;
						end
					end
					ST_GR_JOB: begin
						gend_q <= job_end_new;
						jc_q <= jc_q + JCW'(1);
						ok_q <= 1'b1;
						state_q <= ST_GR_DONE;
					end
					ST_GR_DONE: begin
						ev_addr_q <= ok_q ? gaddr_q : '0;
						ev_len_q <= gsize_q;
						ev_end_q <= ok_q ? gend_q : '0;
						ev_last_q <= 1'b0;
						if (op_q == ffa_pkg::OP_REQUEST) begin
							ret_q <= ST_STATUS;
							state_q <= ST_EMIT;
							if (ok_q) begin
								ev_kind_q <= ffa_pkg::EV_GRANT;
							end else if (wc_q < WCW'(WAIT_DEPTH)) begin
								tail_q <= (tail_q == WAW'(WAIT_DEPTH - 1)) ? '0
								          : tail_q + WAW'(1);
								wc_q <= wc_q + WCW'(1);
								waited_q <= waited_q + TW'(1);
								ev_kind_q <= ffa_pkg::EV_QUEUED;
							end else begin
								ev_kind_q <= ffa_pkg::EV_OVERFLOW;
							end
						end else if (ok_q) begin
							head_q <= (head_q == WAW'(WAIT_DEPTH - 1)) ? '0
							          : head_q + WAW'(1);
							wc_q <= wc_q - WCW'(1);
							ev_kind_q <= ffa_pkg::EV_GRANT;
							ret_q <= ST_WQ_RD;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_STATUS;
						end
					end
					ST_STATUS: begin
						ev_kind_q <= ffa_pkg::EV_STATUS;
						ev_addr_q <= '0;
						ev_len_q <= '0;
						ev_end_q <= '0;
						ev_last_q <= 1'b1;
						ret_q <= ST_IDLE;
						state_q <= ST_EMIT;
					end
					ST_EMIT: begin
						if (!m_tvalid_q || m_tready) begin
							m_tvalid_q <= 1'b1;
							m_tuser_q <= ev_kind_q;
							m_tlast_q <= ev_last_q;
							m_tdata_q <= {1'b0, busy, waited_q, tick_q, ev_end_q,
							              ev_len_q, ev_addr_q};
							state_q <= ret_q;
						end
					end
					default: state_q <= ST_INIT;
				endcase
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;
endmodule

@@ hw/rtl/ffa_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
`include "first_fit_allocator_with_wait_queue_assert.svh"

module ffa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ffa_pkg::MDataW-1:0]    m_tdata,
	input logic [ffa_pkg::KindW-1:0]     m_tuser,
	input logic                          m_tlast
);
	`FFA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")
	`FFA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken again before item finished")
	`FFA_ASSERT_IMP(a_last_is_status, m_tvalid, m_tlast == (m_tuser == ffa_pkg::EV_STATUS), "tlast not on status beat")
	`FFA_ASSERT_IMP(a_grant_busy, m_tvalid && (m_tuser == ffa_pkg::EV_GRANT), m_tdata[158], "grant without busy flag")
endmodule

bind first_fit_allocator_with_wait_queue ffa_checker u_ffa_checker (.*);
